// ===== design/chacha_pkg.sv =====
// Shared types, constants and the microcode program of the ChaCha block cipher unit.
package chacha_pkg;

  localparam int unsigned WordW  = 64;
  localparam int unsigned StepW  = 3;
  localparam int unsigned RoundW = 4;
  localparam int unsigned AddrW  = 6;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_KEY_0      = 3'd0,
    REG_KEY_1      = 3'd1,
    REG_KEY_2      = 3'd2,
    REG_KEY_3      = 3'd3,
    REG_KEY_IS_256 = 3'd4,
    REG_NONCE      = 3'd5,
    REG_EIGHT_RND  = 3'd6,
    REG_NONE       = 3'd7
  } reg_idx_e;

  // Constant words: "expand 32-byte k" and "expand 16-byte k"
  localparam logic [3:0][31:0] Sigma = {32'h6b206574, 32'h79622d32, 32'h3320646e, 32'h61707865};
  localparam logic [3:0][31:0] Tau   = {32'h6b206574, 32'h79622d36, 32'h3120646e, 32'h61707865};

  // Double rounds less one, loaded into the round counter
  localparam logic [RoundW-1:0] Doubles20 = RoundW'(9);
  localparam logic [RoundW-1:0] Doubles8  = RoundW'(3);

  typedef struct packed {
    logic             first_block;
    logic [WordW-1:0] plain_word_7;
    logic [WordW-1:0] plain_word_6;
    logic [WordW-1:0] plain_word_5;
    logic [WordW-1:0] plain_word_4;
    logic [WordW-1:0] plain_word_3;
    logic [WordW-1:0] plain_word_2;
    logic [WordW-1:0] plain_word_1;
    logic [WordW-1:0] plain_word_0;
  } in_beat_t;

  typedef struct packed {
    logic [WordW-1:0] cipher_word_7;
    logic [WordW-1:0] cipher_word_6;
    logic [WordW-1:0] cipher_word_5;
    logic [WordW-1:0] cipher_word_4;
    logic [WordW-1:0] cipher_word_3;
    logic [WordW-1:0] cipher_word_2;
    logic [WordW-1:0] cipher_word_1;
    logic [WordW-1:0] cipher_word_0;
  } out_beat_t;

  // Datapath operations
  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_HALF1 = 2'd1,
    OP_HALF2 = 2'd2,
    OP_FINAL = 2'd3
  } op_e;

  // Sequencing: SEQ steps on, WAIT_IN / WAIT_OUT hold until the channel allows
  // and then jump, LOOP jumps back while double rounds remain.
  typedef enum logic [1:0] {
    JMP_SEQ      = 2'd0,
    JMP_WAIT_IN  = 2'd1,
    JMP_LOOP     = 2'd2,
    JMP_WAIT_OUT = 2'd3
  } jmp_e;

  typedef struct packed {
    op_e              op;
    logic             diag;
    jmp_e             jmp;
    logic [StepW-1:0] target;
  } ucode_t;

  function automatic ucode_t ucode_rom(input logic [StepW-1:0] step);
    ucode_t w;
    unique case (step)
      3'd0:    w = '{op: OP_LOAD,  diag: 1'b0, jmp: JMP_WAIT_IN,  target: 3'd1};
      3'd1:    w = '{op: OP_HALF1, diag: 1'b0, jmp: JMP_SEQ,      target: 3'd0};
      3'd2:    w = '{op: OP_HALF2, diag: 1'b0, jmp: JMP_SEQ,      target: 3'd0};
      3'd3:    w = '{op: OP_HALF1, diag: 1'b1, jmp: JMP_SEQ,      target: 3'd0};
      3'd4:    w = '{op: OP_HALF2, diag: 1'b1, jmp: JMP_LOOP,     target: 3'd1};
      3'd5:    w = '{op: OP_FINAL, diag: 1'b0, jmp: JMP_WAIT_OUT, target: 3'd0};
      default: w = '{op: OP_FINAL, diag: 1'b0, jmp: JMP_WAIT_OUT, target: 3'd0};
    endcase
    return w;
  endfunction

endpackage

// ===== design/chacha_block_stream_cipher_unit.sv =====
// ChaCha block cipher unit: microcoded round sequencer, block counter and APB registers.
//
//   channel | direction | handshake                 | beat
//   --------+-----------+---------------------------+-------------------------------
//   in      | input     | in_valid_i / in_stall_o   | first_block, plain_word_0..7
//   out     | output    | out_valid_o / out_stall_i | cipher_word_0..7
//   cfg     | input     | psel/penable/pwrite/pready| 64-bit register at paddr 8*i
//
// A block runs D double rounds, 10 at 20 rounds and 4 at 8, on the four-lane half
// quarter round unit, which does one half of a column or diagonal round per cycle.
// The next block can be accepted in the cycle after the result is loaded, so blocks
// do not overlap. The result may still wait in the output register meanwhile; a
// stalled output holds the final step.
// Reset clears the configuration registers, the block counter and the sequencer; the payload registers are not reset.
module chacha_block_stream_cipher_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  chacha_pkg::in_beat_t             in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output chacha_pkg::out_beat_t            out_data_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [chacha_pkg::AddrW-1:0]     paddr,
  input  logic [chacha_pkg::WordW-1:0]     pwdata,
  output logic [chacha_pkg::WordW-1:0]     prdata,
  output logic                             pready
);
  import chacha_pkg::*;

  typedef logic [15:0][31:0] state_t;
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } quad_t;

  // Configuration
  logic [3:0][WordW-1:0] key_q;
  logic                  key_is_256_q;
  logic [WordW-1:0]      nonce_q;
  logic                  eight_rounds_q;
  reg_idx_e              cfg_idx;
  logic                  cfg_wr;

  // Sequencer and datapath
  logic [StepW-1:0]  step_q, step_d;
  logic [RoundW-1:0] rnd_q, rnd_d;
  logic [WordW-1:0]  ctr_q, ctr_d;
  logic              out_valid_q, out_valid_d;
  state_t            x_q, x_d;
  state_t            init_q;
  state_t            init_w;
  logic [511:0]      plain_q;
  out_beat_t         out_q;
  out_beat_t         out_w;
  ucode_t            uc;
  logic              in_acc;
  logic              out_free;
  logic [WordW-1:0]  ctr_base;
  state_t            x_half;

  function automatic quad_t qr_half(input quad_t q, input logic second);
    quad_t r;
    logic [31:0] t;
    r.a = q.a + q.b;
    t   = q.d ^ r.a;
    r.d = second ? {t[23:0], t[31:24]} : {t[15:0], t[31:16]};
    r.c = q.c + r.d;
    t   = q.b ^ r.c;
    r.b = second ? {t[24:0], t[31:25]} : {t[19:0], t[31:20]};
    return r;
  endfunction

  assign cfg_idx = reg_idx_e'(paddr[AddrW-1:3]);
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign pready  = 1'b1;

  always_comb begin
    unique case (cfg_idx)
      REG_KEY_0:      prdata = key_q[0];
      REG_KEY_1:      prdata = key_q[1];
      REG_KEY_2:      prdata = key_q[2];
      REG_KEY_3:      prdata = key_q[3];
      REG_KEY_IS_256: prdata = {{(WordW-1){1'b0}}, key_is_256_q};
      REG_NONCE:      prdata = nonce_q;
      REG_EIGHT_RND:  prdata = {{(WordW-1){1'b0}}, eight_rounds_q};
      default:        prdata = '0;
    endcase
  end

  assign uc         = ucode_rom(step_q);
  assign in_stall_o = (uc.op != OP_LOAD);
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign out_free   = ~out_valid_q | ~out_stall_i;
  assign ctr_base   = in_data_i.first_block ? '0 : ctr_q;

  // Input state from constant, key, counter and nonce
  always_comb begin
    init_w[3:0]   = key_is_256_q ? Sigma : Tau;
    init_w[5:4]   = key_q[0];
    init_w[7:6]   = key_q[1];
    init_w[9:8]   = key_is_256_q ? key_q[2] : key_q[0];
    init_w[11:10] = key_is_256_q ? key_q[3] : key_q[1];
    init_w[13:12] = ctr_base;
    init_w[15:14] = nonce_q;
  end

  // Four lanes of half a quarter round, on columns or diagonals
  always_comb begin
    logic [1:0] sb, sc, sd;
    quad_t      q, r;
    x_half = x_q;
    for (int l = 0; l < 4; l++) begin
      sb = 2'(l) + {1'b0, uc.diag};
      sc = 2'(l) + {uc.diag, 1'b0};
      sd = 2'(l) + {uc.diag, uc.diag};
      q.a = x_q[{2'b00, 2'(l)}];
      q.b = x_q[{2'b01, sb}];
      q.c = x_q[{2'b10, sc}];
      q.d = x_q[{2'b11, sd}];
      r = qr_half(q, uc.op == OP_HALF2);
      x_half[{2'b00, 2'(l)}] = r.a;
      x_half[{2'b01, sb}]    = r.b;
      x_half[{2'b10, sc}]    = r.c;
      x_half[{2'b11, sd}]    = r.d;
    end
  end

  // Keystream: rounds output plus input state, xored into the block
  always_comb begin
    logic [511:0] ks;
    for (int i = 0; i < 16; i++) begin
      ks[32*i +: 32] = x_q[i] + init_q[i];
    end
    out_w = out_beat_t'(plain_q ^ ks);
  end

  always_comb begin
    step_d      = step_q;
    rnd_d       = rnd_q;
    ctr_d       = ctr_q;
    out_valid_d = out_valid_q & out_stall_i;
    x_d         = x_q;
    case (uc.op)
      OP_LOAD: begin
        if (in_acc) begin
          x_d   = init_w;
          ctr_d = ctr_base + WordW'(1);
          rnd_d = eight_rounds_q ? Doubles8 : Doubles20;
        end
      end
      OP_HALF1, OP_HALF2: x_d = x_half;
      OP_FINAL: begin
        if (out_free) begin
          out_valid_d = 1'b1;
        end
      end
      default: x_d = x_q;
    endcase
    unique case (uc.jmp)
      JMP_SEQ:      step_d = step_q + StepW'(1);
      JMP_WAIT_IN:  step_d = in_acc ? uc.target : step_q;
      JMP_WAIT_OUT: step_d = out_free ? uc.target : step_q;
      JMP_LOOP: begin
        if (rnd_q != '0) begin
          step_d = uc.target;
          rnd_d  = rnd_q - RoundW'(1);
        end else begin
          step_d = step_q + StepW'(1);
        end
      end
      default: step_d = step_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q          <= '0;
      key_is_256_q   <= 1'b0;
      nonce_q        <= '0;
      eight_rounds_q <= 1'b0;
      step_q         <= '0;
      rnd_q          <= '0;
      ctr_q          <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_idx)
          REG_KEY_0:      key_q[0]       <= pwdata;
          REG_KEY_1:      key_q[1]       <= pwdata;
          REG_KEY_2:      key_q[2]       <= pwdata;
          REG_KEY_3:      key_q[3]       <= pwdata;
          REG_KEY_IS_256: key_is_256_q   <= pwdata[0];
          REG_NONCE:      nonce_q        <= pwdata;
          REG_EIGHT_RND:  eight_rounds_q <= pwdata[0];
          default:        ;
        endcase
      end
      step_q      <= step_d;
      rnd_q       <= rnd_d;
      ctr_q       <= ctr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    if (in_acc) begin
      init_q  <= init_w;
      plain_q <= in_data_i[511:0];
    end
    if (uc.op == OP_FINAL && out_free) begin
      out_q <= out_w;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
